### hw/rtl/mte_pkg.sv
package mte_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ON,
        ST_OFF,
        ST_GAP,
        ST_WORD
    } t_state;

    // Morse code of one character.
    // len:  number of elements (0: the byte has no code).
    // dash: one bit per element, first element in bit 0; 1 = dash, 0 = dot.
    typedef struct packed {
        logic [2:0] len;
        logic [4:0] dash;
    } t_code;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic emit;
        logic key;
        logic next_elem;
        logic load_ar;
        logic run_end;
        logic msg_end;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        logic coded;
        logic sep_gap;
        logic fin_ar;
        logic is_dash;
        logic last_elem;
        logic ar_pend;
        logic is_ar;
        logic slot_free;
    } t_dp_status;

    localparam t_code CODE_AR = '{len: 3'd5, dash: 5'b01010};

    // Units of an element and gaps, counted from zero
    localparam logic [1:0] DOT_LAST  = 2'd0;
    localparam logic [1:0] DASH_LAST = 2'd2;
    localparam logic [1:0] CGAP_LAST = 2'd1;
    localparam logic [1:0] WGAP_LAST = 2'd3;

    function automatic t_code char_code(input logic [7:0] c);
        t_code r;
        r = '{len: 3'd0, dash: 5'b00000};
        unique case (c)
            8'h41: r = '{3'd2, 5'b00010}; // A
            8'h42: r = '{3'd4, 5'b00001};
            8'h43: r = '{3'd4, 5'b00101};
            8'h44: r = '{3'd3, 5'b00001};
            8'h45: r = '{3'd1, 5'b00000};
            8'h46: r = '{3'd4, 5'b00100};
            8'h47: r = '{3'd3, 5'b00011};
            8'h48: r = '{3'd4, 5'b00000};
            8'h49: r = '{3'd2, 5'b00000};
            8'h4A: r = '{3'd4, 5'b01110};
            8'h4B: r = '{3'd3, 5'b00101};
            8'h4C: r = '{3'd4, 5'b00010};
            8'h4D: r = '{3'd2, 5'b00011};
            8'h4E: r = '{3'd2, 5'b00001};
            8'h4F: r = '{3'd3, 5'b00111};
            8'h50: r = '{3'd4, 5'b00110};
            8'h51: r = '{3'd4, 5'b01011};
            8'h52: r = '{3'd3, 5'b00010};
            8'h53: r = '{3'd3, 5'b00000};
            8'h54: r = '{3'd1, 5'b00001};
            8'h55: r = '{3'd3, 5'b00100};
            8'h56: r = '{3'd4, 5'b01000};
            8'h57: r = '{3'd3, 5'b00110};
            8'h58: r = '{3'd4, 5'b01001};
            8'h59: r = '{3'd4, 5'b01101};
            8'h5A: r = '{3'd4, 5'b00011}; // Z
            8'h30: r = '{3'd5, 5'b11111}; // 0
            8'h31: r = '{3'd5, 5'b11110};
            8'h32: r = '{3'd5, 5'b11100};
            8'h33: r = '{3'd5, 5'b11000};
            8'h34: r = '{3'd5, 5'b10000};
            8'h35: r = '{3'd5, 5'b00000};
            8'h36: r = '{3'd5, 5'b00001};
            8'h37: r = '{3'd5, 5'b00011};
            8'h38: r = '{3'd5, 5'b00111};
            8'h39: r = '{3'd5, 5'b01111}; // 9
            default: r = '{len: 3'd0, dash: 5'b00000};
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/mte_in_if.sv
interface mte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_char;

    modport source (output valid, output text_byte, output final_char, input ready);
    modport sink   (input valid, input text_byte, input final_char, output ready);
endinterface

### hw/rtl/mte_out_if.sv
interface mte_out_if;
    logic valid;
    logic ready;
    logic key_bit;
    logic run_end;
    logic message_end;

    modport source (output valid, output key_bit, output run_end, output message_end,
                    input ready);
    modport sink   (input valid, input key_bit, input run_end, input message_end,
                    output ready);
endinterface

### hw/rtl/morse_text_encoder_core.sv
// Channel   Dir  Payload                              Handshake
// i_text    in   text_byte[7:0], final_char           valid/ready
// o_key     out  key_bit, run_end, message_end        valid/ready
//
// One key bit leaves per cycle while o_key takes it; the controller only
// steps when the output register is free.
// An item yields up to 22 key bits for a character and 38 for a character
// followed by AR; some items yield no key bits at all.
// The next item is taken once the last bit of the current one is in the
// output register. Reset is synchronous, active low, and returns to idle
// with an empty message. A stalled o_key holds the controller in place.
module morse_text_encoder_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mte_in_if.sink    i_text,
    mte_out_if.source o_key
);
    import mte_pkg::*;

    // Command and status between controller and datapath
    t_dp_cmd    cmd;
    t_dp_status status;

    // Datapath: code table lookup, element shifter, message flags and
    // the output register
    mte_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_text   (i_text),
        .o_key    (o_key),
        .i_cmd    (cmd),
        .o_status (status)
    );

    // Controller: sequences dots, dashes, element, character and word gaps,
    // and appends AR at the end of a message
    mte_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

endmodule

### hw/rtl/mte_datapath.sv
module mte_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mte_in_if.sink              i_text,
    mte_out_if.source           o_key,
    input  mte_pkg::t_dp_cmd    i_cmd,
    output mte_pkg::t_dp_status o_status
);
    import mte_pkg::*;

    logic       accept;
    t_code      in_code;
    logic       coded;

    logic [4:0] r_dash,  n_dash;
    logic [2:0] r_left,  n_left;
    logic       r_ar_pend, n_ar_pend;
    logic       r_is_ar,   n_is_ar;
    logic       r_started, n_started;
    logic       r_gap,     n_gap;

    logic       r_out_valid;
    logic       r_key, r_run_end, r_msg_end;

    assign i_text.ready = i_cmd.in_ready;
    assign accept       = i_text.valid && i_cmd.in_ready;
    assign in_code      = char_code(i_text.text_byte);
    assign coded        = (in_code.len != 3'd0);

    assign o_status.in_valid  = i_text.valid;
    assign o_status.coded     = coded;
    assign o_status.sep_gap   = r_started && !r_gap;
    assign o_status.fin_ar    = i_text.final_char && r_started;
    assign o_status.is_dash   = r_dash[0];
    assign o_status.last_elem = (r_left == 3'd1);
    assign o_status.ar_pend   = r_ar_pend;
    assign o_status.is_ar     = r_is_ar;
    assign o_status.slot_free = !r_out_valid || o_key.ready;

    always_comb begin
        n_dash    = r_dash;
        n_left    = r_left;
        n_ar_pend = r_ar_pend;
        n_is_ar   = r_is_ar;
        n_started = r_started;
        n_gap     = r_gap;
        if (accept) begin
            if (coded) begin
                n_dash    = in_code.dash;
                n_left    = in_code.len;
                n_is_ar   = 1'b0;
                n_ar_pend = i_text.final_char;
                n_started = 1'b1;
                n_gap     = 1'b0;
            end else if (r_started && !r_gap) begin
                n_ar_pend = i_text.final_char;
                n_gap     = 1'b1;
            end else if (i_text.final_char && r_started) begin
                // Run of separators already gapped: send AR directly
                n_dash    = CODE_AR.dash;
                n_left    = CODE_AR.len;
                n_is_ar   = 1'b1;
                n_ar_pend = 1'b0;
            end
            if (i_text.final_char) begin
                n_started = 1'b0;
                n_gap     = 1'b0;
            end
        end else if (i_cmd.load_ar) begin
            n_dash    = CODE_AR.dash;
            n_left    = CODE_AR.len;
            n_is_ar   = 1'b1;
            n_ar_pend = 1'b0;
        end else if (i_cmd.next_elem) begin
            n_dash = {1'b0, r_dash[4:1]};
            n_left = r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ar_pend   <= 1'b0;
            r_is_ar     <= 1'b0;
            r_started   <= 1'b0;
            r_gap       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ar_pend <= n_ar_pend;
            r_is_ar   <= n_is_ar;
            r_started <= n_started;
            r_gap     <= n_gap;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_key.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dash <= n_dash;
        r_left <= n_left;
        if (i_cmd.emit) begin
            r_key     <= i_cmd.key;
            r_run_end <= i_cmd.run_end;
            r_msg_end <= i_cmd.msg_end;
        end
    end

    assign o_key.valid       = r_out_valid;
    assign o_key.key_bit     = r_key;
    assign o_key.run_end     = r_run_end;
    assign o_key.message_end = r_msg_end;

endmodule

### hw/rtl/mte_ctrl.sv
module mte_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mte_pkg::t_dp_status i_status,
    output mte_pkg::t_dp_cmd    o_cmd
);
    import mte_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_unit,  n_unit;
    logic [1:0] on_last;

    assign on_last = i_status.is_dash ? DASH_LAST : DOT_LAST;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_status.in_valid) begin
                    priority if (i_status.coded)   n_state = ST_ON;
                    else if (i_status.sep_gap)     n_state = ST_WORD;
                    else if (i_status.fin_ar)      n_state = ST_ON;
                    else                           n_state = ST_IDLE;
                end
            end
            ST_ON: begin
                if (i_status.slot_free && r_unit == on_last) n_state = ST_OFF;
            end
            ST_OFF: begin
                if (i_status.slot_free) begin
                    n_state = i_status.last_elem ? ST_GAP : ST_ON;
                end
            end
            ST_GAP: begin
                if (i_status.slot_free && r_unit == CGAP_LAST) begin
                    n_state = i_status.ar_pend ? ST_ON : ST_IDLE;
                end
            end
            ST_WORD: begin
                if (i_status.slot_free && r_unit == WGAP_LAST) begin
                    n_state = i_status.ar_pend ? ST_ON : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: o_cmd.in_ready = 1'b1;
            ST_ON: begin
                o_cmd.emit = i_status.slot_free;
                o_cmd.key  = 1'b1;
            end
            ST_OFF: begin
                o_cmd.emit      = i_status.slot_free;
                o_cmd.next_elem = i_status.slot_free && !i_status.last_elem;
            end
            ST_GAP: begin
                o_cmd.emit = i_status.slot_free;
                if (r_unit == CGAP_LAST) begin
                    o_cmd.load_ar = i_status.slot_free && i_status.ar_pend;
                    o_cmd.run_end = !i_status.ar_pend;
                    o_cmd.msg_end = !i_status.ar_pend && i_status.is_ar;
                end
            end
            ST_WORD: begin
                o_cmd.emit = i_status.slot_free;
                if (r_unit == WGAP_LAST) begin
                    o_cmd.load_ar = i_status.slot_free && i_status.ar_pend;
                    o_cmd.run_end = !i_status.ar_pend;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    // Unit counter: restart on every state change
    always_comb begin
        n_unit = r_unit;
        if (n_state != r_state) begin
            n_unit = 2'd0;
        end else if (o_cmd.emit) begin
            n_unit = r_unit + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_unit  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_unit  <= n_unit;
        end
    end

    a_idle_no_ar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !i_status.ar_pend)
        else $error("AR still pending while idle");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.slot_free)
        else $error("key bit emitted into a full output slot");

    a_long_on_dash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ON && r_unit != 2'd0) |-> i_status.is_dash)
        else $error("dot held on longer than one unit");

    a_msg_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.msg_end |-> o_cmd.run_end)
        else $error("message end not on the last bit of the item");

endmodule

### dv/morse_text_encoder_core_tb.sv
module morse_text_encoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_char;
    } t_text_item;

    typedef struct packed {
        logic key_bit;
        logic run_end;
        logic message_end;
    } t_key_unit;

    localparam int AR_SLOT = 36;

    // Dot/dash patterns: A-Z, then 0-9, then the AR prosign.
    string morse_tab [37] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
        "---..", "----.",
        ".-.-."
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    mte_in_if  text_if ();
    mte_out_if key_if ();

    morse_text_encoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_if),
        .o_key   (key_if)
    );

    t_text_item pending_text [$];
    t_key_unit  expected_keys [$];

    // Encoder state as seen by the predictor
    logic in_message;
    logic word_gap_sent;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic rx_hold = 1'b0;
    logic hold_req = 1'b0;

    int errors = 0;
    int items_sent = 0;
    int bits_checked = 0;
    int prosigns_seen = 0;

    always #5 i_clk = ~i_clk;

    function automatic int code_index(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return int'(c - "A");
        if (c >= "0" && c <= "9") return 26 + int'(c - "0");
        return -1;
    endfunction

    task automatic push_key(input logic k);
        t_key_unit u;
        u = '{key_bit: k, run_end: 1'b0, message_end: 1'b0};
        expected_keys.push_back(u);
    endtask

    // Each element keys on for one (dot) or three (dash) units, then one off;
    // the character closes with two more off units.
    task automatic emit_symbol(input int idx);
        string pat;
        pat = morse_tab[idx];
        for (int k = 0; k < pat.len(); k++) begin
            push_key(1'b1);
            if (pat[k] == "-") begin
                push_key(1'b1);
                push_key(1'b1);
            end
            push_key(1'b0);
        end
        push_key(1'b0);
        push_key(1'b0);
    endtask

    task automatic predict_text_item(input logic [7:0] c, input logic fin);
        int first;
        int idx;
        first = expected_keys.size();
        idx = code_index(c);
        if (idx >= 0) begin
            emit_symbol(idx);
            in_message = 1'b1;
            word_gap_sent = 1'b0;
        end else if (in_message && !word_gap_sent) begin
            // first separator after a character: one word gap for the run
            repeat (4) push_key(1'b0);
            word_gap_sent = 1'b1;
        end
        if (fin) begin
            if (in_message) begin
                emit_symbol(AR_SLOT);
                expected_keys[expected_keys.size() - 1].message_end = 1'b1;
            end
            in_message = 1'b0;
            word_gap_sent = 1'b0;
        end
        if (expected_keys.size() > first)
            expected_keys[expected_keys.size() - 1].run_end = 1'b1;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic add_item(input logic [7:0] c, input logic fin);
        t_text_item it;
        it = '{text_byte: c, final_char: fin};
        pending_text.push_back(it);
    endtask

    function automatic logic [7:0] random_coded();
        int idx;
        idx = $urandom_range(35);
        return (idx < 26) ? 8'("A" + idx) : 8'("0" + idx - 26);
    endfunction

    function automatic logic [7:0] random_separator();
        logic [7:0] c;
        case ($urandom_range(2))
            0: c = " ";
            1: c = 8'("a" + $urandom_range(25));
            default: begin
                c = 8'($urandom_range(255));
                while (code_index(c) >= 0) c = 8'($urandom_range(255));
            end
        endcase
        return c;
    endfunction

    // Mostly well-formed messages ending in a final character, with some
    // separator runs and raw noise mixed in.
    task automatic add_random(input int count);
        int made;
        int len;
        logic [7:0] c;
        made = 0;
        while (made < count) begin
            if ($urandom_range(99) < 20) begin
                add_item(8'($urandom_range(255)), ($urandom_range(7) == 0));
                made++;
            end else begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    c = ($urandom_range(99) < 75) ? random_coded() : random_separator();
                    add_item(c, (k == len - 1));
                    made++;
                    if ($urandom_range(99) < 10 && k != len - 1) begin
                        add_item(random_separator(), 1'b0);
                        made++;
                    end
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_text.size() != 0 || text_if.valid || expected_keys.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        text_if.valid = 1'b0;
        text_if.text_byte = 8'h00;
        text_if.final_char = 1'b0;
        key_if.ready = 1'b0;
        in_message = 1'b0;
        word_gap_sent = 1'b0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Sender: offer the next pending item, hold it until taken.
    always @(posedge i_clk) begin : drive_text
        t_text_item nxt;
        logic offer;
        if (!i_rst_n) begin
            text_if.valid <= 1'b0;
        end else begin
            if (text_if.valid && text_if.ready) begin
                predict_text_item(text_if.text_byte, text_if.final_char);
                items_sent++;
            end
            if (!text_if.valid || text_if.ready) begin
                offer = (pending_text.size() != 0) && ($urandom_range(99) >= tx_idle_pct);
                if (offer) begin
                    nxt = pending_text.pop_front();
                    text_if.valid <= 1'b1;
                    text_if.text_byte <= nxt.text_byte;
                    text_if.final_char <= nxt.final_char;
                end else begin
                    text_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each taken key bit against the oldest expectation.
    always @(posedge i_clk) begin : check_keys
        t_key_unit want;
        if (i_rst_n && key_if.valid && key_if.ready) begin
            if (expected_keys.size() == 0) begin
                report_mismatch($sformatf("key bit %b with nothing expected", key_if.key_bit));
            end else begin
                want = expected_keys.pop_front();
                if (key_if.key_bit !== want.key_bit)
                    report_mismatch($sformatf("bit %0d key_bit %b, want %b",
                                              bits_checked, key_if.key_bit, want.key_bit));
                if (key_if.run_end !== want.run_end)
                    report_mismatch($sformatf("bit %0d run_end %b, want %b",
                                              bits_checked, key_if.run_end, want.run_end));
                if (key_if.message_end !== want.message_end)
                    report_mismatch($sformatf("bit %0d message_end %b, want %b",
                                              bits_checked, key_if.message_end,
                                              want.message_end));
                if (want.message_end) prosigns_seen++;
            end
            bits_checked++;
        end
        key_if.ready <= i_rst_n && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Long output stall: the sender keeps offering so the encoder backs up.
    initial begin
        wait (hold_req);
        @(negedge i_clk);
        rx_hold = 1'b1;
        repeat (300) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("morse_text_encoder_core_tb failed");
        $finish;
    end

    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);
        tx_idle_pct = 23;
        rx_idle_pct = 76;

        // leading separators, dropped
        add_item(8'h20, 1'b0);
        add_item(8'h00, 1'b0);
        // table edges and the corrected C
        add_item("A", 1'b0);
        add_item("Z", 1'b0);
        add_item("0", 1'b0);
        add_item("9", 1'b0);
        add_item("C", 1'b0);
        add_item("E", 1'b0);
        add_item("T", 1'b0);
        // separator run: gap once, lower case and 0xFF add nothing
        add_item(" ", 1'b0);
        add_item("a", 1'b0);
        add_item(8'hFF, 1'b0);
        add_item("5", 1'b1);
        // final with nothing emitted: no prosign
        add_item(8'h7F, 1'b1);
        // bytes just outside the coded ranges, between coded characters
        add_item("/", 1'b0);
        add_item("Q", 1'b0);
        add_item(":", 1'b0);
        add_item("@", 1'b0);
        add_item("[", 1'b0);
        add_item("K", 1'b0);
        add_item(".", 1'b1);
        add_item("M", 1'b0);
        add_item(8'h80, 1'b0);
        add_item("0", 1'b1);
        add_random(60);
        wait_drained();

        tx_idle_pct = 76;
        rx_idle_pct = 23;
        add_random(60);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        add_random(70);
        wait_drained();

        repeat (45) @(negedge i_clk);
        $display("Covered %0d text items, %0d key bits and %0d prosigns,",
                 items_sent, bits_checked, prosigns_seen);
        $display("under three idling mixes and one long output stall.");
        if (errors == 0) begin
            $display("morse_text_encoder_core_tb passed");
        end else begin
            $display("morse_text_encoder_core_tb failed");
        end
        $finish;
    end

endmodule

### morse_text_encoder_core.f
hw/rtl/mte_pkg.sv
hw/rtl/mte_in_if.sv
hw/rtl/mte_out_if.sv
hw/rtl/mte_datapath.sv
hw/rtl/mte_ctrl.sv
hw/rtl/morse_text_encoder_core.sv
dv/morse_text_encoder_core_tb.sv
